// File: rtl/hsl_pkg.sv
`timescale 1ns / 1ps

package hsl_pkg;

  // field and internal widths
  localparam int ChanW  = 8;
  localparam int PosW   = 11;   // hue position, one turn is 1536
  localparam int PivotW = 16;   // pivot levels in 2^16 units
  localparam int OffW   = 9;    // ramp offset, 0 to 256
  localparam int LevelW = 24;   // channel level in 2^24 units
  localparam int NumChan = 3;

  // hue positions in sixths of a turn scaled by 256
  localparam logic [PosW-1:0] TurnPos  = 11'd1536;
  localparam logic [PosW-1:0] ThirdPos = 11'd512;
  localparam logic [PosW-1:0] SixthPos = 11'd256;
  localparam logic [PosW-1:0] HalfPos  = 11'd768;
  localparam logic [PosW-1:0] Two3Pos  = 11'd1024;

  // channel indexes
  localparam int ChRed   = 0;
  localparam int ChGreen = 1;
  localparam int ChBlue  = 2;

  // per-channel interpolation control
  typedef struct packed {
    logic [OffW-1:0] off;      // multiplier for the span
    logic            use_high; // base is the top pivot
  } chan_ctl_t;

  // pick the ramp segment for one hue position
  function automatic chan_ctl_t chan_ctl(input logic [PosW-1:0] pos);
    chan_ctl_t c;
    logic [PosW-1:0] fall;
    fall = Two3Pos - pos;
    c.off = '0;
    c.use_high = 1'b0;
    if (pos < SixthPos) begin
      c.off = OffW'(pos);
    end else if (pos < HalfPos) begin
      c.use_high = 1'b1;
    end else if (pos < Two3Pos) begin
      c.off = OffW'(fall);
    end
    return c;
  endfunction

endpackage

// File: rtl/hsl_in_if.sv
`timescale 1ns / 1ps

interface hsl_in_if;
  logic                       valid;
  logic                       ready;
  logic [hsl_pkg::ChanW-1:0]  hue;
  logic [hsl_pkg::ChanW-1:0]  saturation;
  logic [hsl_pkg::ChanW-1:0]  lightness;

  modport source (output valid, hue, saturation, lightness, input ready);
  modport sink (input valid, hue, saturation, lightness, output ready);
endinterface

// File: rtl/hsl_rgb_if.sv
`timescale 1ns / 1ps

interface hsl_rgb_if;
  logic                       valid;
  logic                       ready;
  logic [hsl_pkg::ChanW-1:0]  red;
  logic [hsl_pkg::ChanW-1:0]  green;
  logic [hsl_pkg::ChanW-1:0]  blue;

  modport source (output valid, red, green, blue, input ready);
  modport sink (input valid, red, green, blue, output ready);
endinterface

// File: rtl/hsl_to_rgb_converter.sv
`timescale 1ns / 1ps

// HSL to RGB pixel converter.
// hsl_in carries one pixel request (hue, saturation, lightness, each x/256)
// with valid/ready; rgb_out returns red, green, blue with valid/ready.
// A request is taken when valid and ready are both high.
// Five register stages: operand product and hue positions, pivot levels and
// segment select, span multiply, level add, scale by 255. A pixel shows on
// rgb_out from the scale register once it has passed through every stage in
// that order. One pixel can be accepted in every cycle while rgb_out is not
// stalled, so throughput is then one pixel per clock.
// Each stage holds its own valid bit and moves forward whenever the stage
// after it is empty or moving, so bubbles close up under a stall.
// When rgb_out is stalled, results back up stage by stage; hsl_in.ready
// drops only once all five stages hold pixels. Nothing is lost or repeated.
// Synchronous reset clears all valid bits; the block holds no other state
// and is ready for a request in the first cycle after reset.
// Zero saturation needs no special path: the pivots collapse to the
// lightness level and every channel comes out grey.
module hsl_to_rgb_converter (
  input  logic      clk,
  input  logic      rst,
  hsl_in_if.sink    hsl_in,
  hsl_rgb_if.source rgb_out
);

  localparam int ChanW  = hsl_pkg::ChanW;
  localparam int PosW   = hsl_pkg::PosW;
  localparam int PivotW = hsl_pkg::PivotW;
  localparam int LevelW = hsl_pkg::LevelW;
  localparam int NumChan = hsl_pkg::NumChan;
  localparam int ProdW  = PivotW + hsl_pkg::OffW;
  localparam int ScaleW = LevelW + ChanW;

  // stage valid bits and advance enables
  logic v1, v2, v3, v4, v5;
  logic en1, en2, en3, en4, en5;

  assign en5 = !v5 || rgb_out.ready;
  assign en4 = !v4 || en5;
  assign en3 = !v3 || en4;
  assign en2 = !v2 || en3;
  assign en1 = !v1 || en2;

  assign hsl_in.ready = en1;

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
      v4 <= 1'b0;
      v5 <= 1'b0;
    end else begin
      if (en1) v1 <= hsl_in.valid;
      if (en2) v2 <= v1;
      if (en3) v3 <= v2;
      if (en4) v4 <= v3;
      if (en5) v5 <= v4;
    end
  end

  // stage 1: lightness times saturation, hue positions
  logic [PivotW-1:0] prod1;
  logic [ChanW-1:0]  lv1, sv1;
  logic [PosW-1:0]   pos1 [NumChan];

  logic [PosW-1:0] pos6, posr_raw, posr, posb;

  always_comb begin
    pos6 = PosW'({hsl_in.hue, 2'b00}) + PosW'({hsl_in.hue, 1'b0});
    posr_raw = pos6 + hsl_pkg::ThirdPos;
    posr = (posr_raw > hsl_pkg::TurnPos) ? posr_raw - hsl_pkg::TurnPos : posr_raw;
    posb = (pos6 < hsl_pkg::ThirdPos) ? pos6 + (hsl_pkg::TurnPos - hsl_pkg::ThirdPos)
                                      : pos6 - hsl_pkg::ThirdPos;
  end

  always_ff @(posedge clk) begin
    if (en1) begin
      prod1 <= PivotW'(hsl_in.lightness * hsl_in.saturation);
      lv1 <= hsl_in.lightness;
      sv1 <= hsl_in.saturation;
      pos1[hsl_pkg::ChRed]   <= posr;
      pos1[hsl_pkg::ChGreen] <= pos6;
      pos1[hsl_pkg::ChBlue]  <= posb;
    end
  end

  // stage 2: pivot levels, span and segment per channel
  logic [PivotW-1:0]      high2, low2, span2;
  hsl_pkg::chan_ctl_t     ctl2 [NumChan];

  logic [PivotW-1:0] l256, s256, high_n, low_n, span_n, s_minus_p;

  always_comb begin
    l256 = {lv1, 8'b0};
    s256 = {sv1, 8'b0};
    s_minus_p = s256 - prod1;
    if (!lv1[ChanW-1]) begin
      // dark half
      high_n = l256 + prod1;
      low_n  = l256 - prod1;
      span_n = {prod1[PivotW-2:0], 1'b0};
    end else begin
      // light half
      high_n = l256 + s_minus_p;
      low_n  = l256 - s_minus_p;
      span_n = {s_minus_p[PivotW-2:0], 1'b0};
    end
  end

  always_ff @(posedge clk) begin
    if (en2) begin
      high2 <= high_n;
      low2  <= low_n;
      span2 <= span_n;
      for (int c = 0; c < NumChan; c++) begin
        ctl2[c] <= hsl_pkg::chan_ctl(pos1[c]);
      end
    end
  end

  // stage 3: span times ramp offset, base pivot
  logic [LevelW-1:0] mult3 [NumChan];
  logic [PivotW-1:0] base3 [NumChan];
  logic [ProdW-1:0]  mult_n [NumChan];

  always_comb begin
    for (int c = 0; c < NumChan; c++) begin
      mult_n[c] = ProdW'(span2) * ProdW'(ctl2[c].off);
    end
  end

  always_ff @(posedge clk) begin
    if (en3) begin
      for (int c = 0; c < NumChan; c++) begin
        mult3[c] <= mult_n[c][LevelW-1:0];
        base3[c] <= ctl2[c].use_high ? high2 : low2;
      end
    end
  end

  // stage 4: channel level in 2^24 units
  logic [LevelW-1:0] level4 [NumChan];

  always_ff @(posedge clk) begin
    if (en4) begin
      for (int c = 0; c < NumChan; c++) begin
        level4[c] <= {base3[c], 8'b0} + mult3[c];
      end
    end
  end

  // stage 5: floor(level * 255 / 2^24)
  logic [ChanW-1:0]  byte5 [NumChan];
  logic [ScaleW-1:0] scaled_n [NumChan];

  always_comb begin
    for (int c = 0; c < NumChan; c++) begin
      scaled_n[c] = {level4[c], 8'b0} - ScaleW'(level4[c]);
    end
  end

  always_ff @(posedge clk) begin
    if (en5) begin
      for (int c = 0; c < NumChan; c++) begin
        byte5[c] <= scaled_n[c][ScaleW-1:LevelW];
      end
    end
  end

  assign rgb_out.valid = v5;
  assign rgb_out.red   = byte5[hsl_pkg::ChRed];
  assign rgb_out.green = byte5[hsl_pkg::ChGreen];
  assign rgb_out.blue  = byte5[hsl_pkg::ChBlue];

  // input stalls only with every stage full and the output held
  a_stall_only_full: assert property (@(posedge clk) disable iff (rst)
    !hsl_in.ready |-> (v1 && v2 && v3 && v4 && v5 && !rgb_out.ready))
    else $error("input stalled with room in the pipeline");

  // a pixel moving out of stage 1 lands in stage 2
  a_stage_move: assert property (@(posedge clk) disable iff (rst)
    (v1 && en2) |=> v2)
    else $error("pixel dropped between stage 1 and stage 2");

  // top pivot never below bottom pivot
  a_pivot_order: assert property (@(posedge clk) disable iff (rst)
    v2 |-> (high2 >= low2))
    else $error("pivot levels out of order");

  // red level add never overflows 2^24
  a_level_range: assert property (@(posedge clk) disable iff (rst)
    v3 |-> ((25'({base3[hsl_pkg::ChRed], 8'b0}) + 25'(mult3[hsl_pkg::ChRed]))
            < 25'h1000000))
    else $error("red level overflow");

endmodule

// File: dv/hsl_to_rgb_converter_tb.sv
`timescale 1ns / 1ps

module hsl_to_rgb_converter_tb;

  typedef struct packed {
    logic [hsl_pkg::ChanW-1:0] hue;
    logic [hsl_pkg::ChanW-1:0] sat;
    logic [hsl_pkg::ChanW-1:0] light;
  } hsl_px_t;

  typedef struct packed {
    logic [hsl_pkg::ChanW-1:0] red;
    logic [hsl_pkg::ChanW-1:0] green;
    logic [hsl_pkg::ChanW-1:0] blue;
  } rgb_px_t;

  localparam int RandPixels   = 1200;
  localparam int StallAfter   = 500;
  localparam int StallCycles  = 80;
  localparam int WatchdogMax  = 2000;
  localparam int DrainCycles  = 12;

  logic clk;
  logic rst;

  hsl_in_if  in_if ();
  hsl_rgb_if out_if ();

  hsl_to_rgb_converter dut (
    .clk     (clk),
    .rst     (rst),
    .hsl_in  (in_if),
    .rgb_out (out_if)
  );

  hsl_px_t pending_pixels[$];
  rgb_px_t rgb_expected[$];

  int  pixels_taken;
  int  failures;
  int  idle_cycles;
  int  send_gap;
  int  ready_gap;
  int  hold_left;
  bit  hold_done;
  bit  in_sent;

  // clock
  always begin
    clk = 1'b0;
    #1;
    clk = 1'b1;
    #1;
  end

  // channel level in 2^24 units for one hue position
  function automatic int unsigned ramp_level(int unsigned pos, int unsigned lo,
                                              int unsigned hi);
    int unsigned span;
    span = hi - lo;
    if (pos < int'(hsl_pkg::SixthPos)) return (lo << 8) + span * pos;
    if (pos < int'(hsl_pkg::HalfPos)) return hi << 8;
    if (pos < int'(hsl_pkg::Two3Pos)) begin
      return (lo << 8) + span * (int'(hsl_pkg::Two3Pos) - pos);
    end
    return lo << 8;
  endfunction

  // scale a 2^24 level to a byte, truncating
  function automatic logic [hsl_pkg::ChanW-1:0] level_byte(int unsigned lvl);
    longint unsigned prod;
    prod = longint'(lvl) * 255;
    return hsl_pkg::ChanW'(prod >> 24);
  endfunction

  // expected rgb for one hsl pixel
  function automatic rgb_px_t predict_rgb(hsl_px_t px);
    int unsigned h, s, l, hi, lo, pos, pos_r, pos_b;
    int unsigned lvl_r, lvl_g, lvl_b;
    rgb_px_t rgb;
    h = px.hue;
    s = px.sat;
    l = px.light;
    if (s == 0) begin
      lvl_r = l << 16;
      lvl_g = lvl_r;
      lvl_b = lvl_r;
    end else begin
      // pivot levels, dark and light halves differ
      if (l < 128) hi = l * (256 + s);
      else hi = l * 256 + s * 256 - l * s;
      lo = 2 * l * 256 - hi;
      // hue positions with wrap around the turn
      pos = 6 * h;
      pos_r = pos + int'(hsl_pkg::ThirdPos);
      if (pos_r > int'(hsl_pkg::TurnPos)) pos_r = pos_r - int'(hsl_pkg::TurnPos);
      if (pos < int'(hsl_pkg::ThirdPos)) begin
        pos_b = pos + int'(hsl_pkg::TurnPos) - int'(hsl_pkg::ThirdPos);
      end else begin
        pos_b = pos - int'(hsl_pkg::ThirdPos);
      end
      lvl_r = ramp_level(pos_r, lo, hi);
      lvl_g = ramp_level(pos, lo, hi);
      lvl_b = ramp_level(pos_b, lo, hi);
    end
    rgb.red   = level_byte(lvl_r);
    rgb.green = level_byte(lvl_g);
    rgb.blue  = level_byte(lvl_b);
    return rgb;
  endfunction

  // idle length, mostly short, a few long, none during burst stretches
  function automatic int pick_gap(int taken);
    int r;
    if ((taken / 150) % 3 == 1) return 0;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 30);
  endfunction

  function automatic hsl_px_t mk_px(int h, int s, int l);
    hsl_px_t px;
    px.hue   = hsl_pkg::ChanW'(h);
    px.sat   = hsl_pkg::ChanW'(s);
    px.light = hsl_pkg::ChanW'(l);
    return px;
  endfunction

  // request driver
  always @(negedge clk) begin
    if (rst) begin
      in_if.valid <= 1'b0;
      send_gap <= 0;
    end else if (!in_if.valid || in_sent) begin
      if (send_gap > 0) begin
        send_gap <= send_gap - 1;
        in_if.valid <= 1'b0;
      end else if (pending_pixels.size() > 0) begin
        hsl_px_t px;
        px = pending_pixels.pop_front();
        in_if.valid      <= 1'b1;
        in_if.hue        <= px.hue;
        in_if.saturation <= px.sat;
        in_if.lightness  <= px.light;
        send_gap <= pick_gap(pixels_taken);
      end else begin
        in_if.valid <= 1'b0;
      end
    end
  end

  // result receiver, with one long hold-off to back up the pipeline
  always @(negedge clk) begin
    if (rst) begin
      out_if.ready <= 1'b0;
      ready_gap <= 0;
      hold_left <= 0;
      hold_done <= 1'b0;
    end else if (!hold_done && pixels_taken >= StallAfter) begin
      hold_done <= 1'b1;
      hold_left <= StallCycles;
      out_if.ready <= 1'b0;
    end else if (hold_left > 0) begin
      hold_left <= hold_left - 1;
      out_if.ready <= 1'b0;
    end else if (ready_gap > 0) begin
      ready_gap <= ready_gap - 1;
      out_if.ready <= 1'b0;
    end else begin
      out_if.ready <= 1'b1;
      ready_gap <= pick_gap(pixels_taken);
    end
  end

  // accept requests, predict, and check results
  always @(posedge clk) begin
    if (rst) begin
      in_sent <= 1'b0;
      idle_cycles <= 0;
    end else begin
      in_sent <= in_if.valid && in_if.ready;
      if (in_if.valid && in_if.ready) begin
        rgb_expected.push_back(predict_rgb(mk_px(in_if.hue, in_if.saturation,
                                                 in_if.lightness)));
        pixels_taken <= pixels_taken + 1;
      end
      if (out_if.valid && out_if.ready) begin
        if (rgb_expected.size() == 0) begin
          $error("unexpected result red=%0d green=%0d blue=%0d",
                 out_if.red, out_if.green, out_if.blue);
          failures++;
        end else begin
          rgb_px_t want;
          want = rgb_expected.pop_front();
          if (out_if.red !== want.red) begin
            $error("red mismatch: expected %0d, got %0d", want.red, out_if.red);
            failures++;
          end
          if (out_if.green !== want.green) begin
            $error("green mismatch: expected %0d, got %0d", want.green, out_if.green);
            failures++;
          end
          if (out_if.blue !== want.blue) begin
            $error("blue mismatch: expected %0d, got %0d", want.blue, out_if.blue);
            failures++;
          end
        end
      end
      // watchdog on cycles with no handshake on either side
      if ((in_if.valid && in_if.ready) || (out_if.valid && out_if.ready)) begin
        idle_cycles <= 0;
      end else if (idle_cycles >= WatchdogMax) begin
        $display("** hsl_to_rgb_converter: FAILED **");
        $finish;
      end else begin
        idle_cycles <= idle_cycles + 1;
      end
    end
  end

  // stimulus and end of run
  initial begin
    int edge_hues[12];
    edge_hues = '{0, 42, 43, 85, 86, 127, 128, 129, 170, 171, 213, 255};
    pixels_taken = 0;
    failures = 0;
    rst = 1'b1;
    in_if.valid = 1'b0;
    in_if.hue = '0;
    in_if.saturation = '0;
    in_if.lightness = '0;
    out_if.ready = 1'b0;

    // grey, lightness extremes and both halves
    pending_pixels.push_back(mk_px(0, 0, 0));
    pending_pixels.push_back(mk_px(255, 0, 255));
    pending_pixels.push_back(mk_px(77, 0, 128));
    pending_pixels.push_back(mk_px(0, 255, 127));
    pending_pixels.push_back(mk_px(0, 255, 128));
    pending_pixels.push_back(mk_px(255, 255, 255));
    pending_pixels.push_back(mk_px(255, 255, 0));
    pending_pixels.push_back(mk_px(0, 1, 1));
    pending_pixels.push_back(mk_px(170, 255, 128));
    // segment edges and both hue wraps, dark and light
    foreach (edge_hues[i]) begin
      pending_pixels.push_back(mk_px(edge_hues[i], 200, (i % 2) ? 180 : 100));
    end

    // random pixels, some grey
    repeat (RandPixels) begin
      pending_pixels.push_back(mk_px($urandom_range(0, 255),
                                     ($urandom_range(0, 15) == 0) ? 0 :
                                     $urandom_range(0, 255),
                                     $urandom_range(0, 255)));
    end

    repeat (3) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    while (pending_pixels.size() > 0 || in_if.valid || rgb_expected.size() > 0) begin
      @(posedge clk);
    end
    repeat (DrainCycles) @(posedge clk);

    if (failures == 0) begin
      $display("** hsl_to_rgb_converter: PASSED **");
    end else begin
      $display("** hsl_to_rgb_converter: FAILED **");
    end
    $finish;
  end

endmodule

// File: hsl_to_rgb_converter.f
rtl/hsl_pkg.sv
rtl/hsl_in_if.sv
rtl/hsl_rgb_if.sv
rtl/hsl_to_rgb_converter.sv
dv/hsl_to_rgb_converter_tb.sv
